[src/assert_macros.svh]
// assertion macros shared by the checker files
// no dependencies
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked on every rising clock edge, including during reset
`define ASSERT_CLK(label, clk, prop, msg) \
   label: assert property (@(posedge clk) prop) else $error(msg);

// property checked only while reset is low
`define ASSERT_RST(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

`endif

[src/lpmr_pkg.sv]
// shared types, constants and helpers for the longest prefix match router
// no dependencies
`default_nettype none

package lpmr_pkg;

   // default route table depth
   localparam int unsigned MAX_ROUTES_DEF = 64;
   // interfaces at or above this index are treated as unreachable
   localparam int unsigned NUM_INTERFACES = 16;
   // longest legal prefix length
   localparam logic [5:0]  MAX_PREFIX_LEN = 6'd32;

   typedef enum logic [2:0] {
      ST_ADDED   = 3'd0,
      ST_FULL    = 3'd1,
      ST_FORWARD = 3'd2,
      ST_EXPIRED = 3'd3,
      ST_NOROUTE = 3'd4
   } status_type;

   typedef enum logic [1:0] {
      OP_ADD     = 2'd0,
      OP_EXPIRED = 2'd1,
      OP_LOOKUP  = 2'd2
   } op_type;

   typedef enum logic {
      BK_IDLE = 1'b0,
      BK_SCAN = 1'b1
   } bk_state_type;

   // classified command between the front and the back
   typedef struct packed {
      op_type      op;
      logic [31:0] prefix;
      logic [5:0]  prefix_len;
      logic        has_gw;
      logic [31:0] gw;
      logic [3:0]  iface;
      logic [31:0] dst;
      logic [7:0]  ttl;
   } cmd_type;

   // one result item
   typedef struct packed {
      status_type  status;
      logic [3:0]  iface;
      logic [31:0] hop;
      logic [7:0]  ttl;
   } rsp_type;

   // one stored route
   typedef struct packed {
      logic [31:0] prefix;
      logic [5:0]  len;
      logic        has_gw;
      logic [31:0] gw;
      logic [3:0]  iface;
   } entry_type;

   // network mask for a prefix length of 0 to 32
   function automatic logic [31:0] len_mask(input logic [5:0] len);
      logic [31:0] mask;
      if (len == 6'd0) begin
         mask = 32'd0;
      end else if (len >= MAX_PREFIX_LEN) begin
         mask = 32'hFFFF_FFFF;
      end else begin
         mask = 32'hFFFF_FFFF << (MAX_PREFIX_LEN - len);
      end
      return mask;
   endfunction

endpackage

`default_nettype wire

[src/longest_prefix_match_router.sv]
// top level of the ipv4 longest prefix match router
// depends on lpmr_pkg, lpmr_front, lpmr_back and lpmr_rsp_q
//
// channel    ports             transfer when          carries
// request    push / full       push && !full          add route or route datagram
// response   empty / pop       pop && !empty          status, interface, hop, ttl
//
// add, table full and expired ttl are answered in the same cycle the command is taken
// a lookup steps through take, one table read per route, the last compare behind
//   the registered read port, then finish
// reset clears the route count and both queues; table contents are not cleared
// two-entry queues on both sides let the front accept while the back works
// and while a finished result waits to be popped
`default_nettype none

module longest_prefix_match_router #(
   parameter int unsigned MAX_ROUTES = lpmr_pkg::MAX_ROUTES_DEF
) (
   input  wire logic        clock,
   input  wire logic        reset,
   // request channel
   input  wire logic        push,
   output logic             full,
   input  wire logic        req_mode,
   input  wire logic [31:0] req_prefix,
   input  wire logic [5:0]  req_prefix_len,
   input  wire logic        req_has_next_hop,
   input  wire logic [31:0] req_gateway_addr,
   input  wire logic [3:0]  req_route_interface,
   input  wire logic [31:0] req_dst_addr,
   input  wire logic [7:0]  req_ttl_in,
   // response channel
   output logic             empty,
   input  wire logic        pop,
   output logic [2:0]       rsp_status,
   output logic [3:0]       rsp_out_interface,
   output logic [31:0]      rsp_hop_addr,
   output logic [7:0]       rsp_ttl_out
);
   import lpmr_pkg::*;

   // front to back command queue
   logic    cmd_empty;
   logic    cmd_pop;
   cmd_type cmd_head;

   // back to result queue
   logic    rsp_push;
   logic    rsp_full;
   rsp_type rsp_data;
   rsp_type rsp_head;

   // classify and queue incoming transfers
   lpmr_front u_front (
      .clock               (clock),
      .reset               (reset),
      .push                (push),
      .full                (full),
      .req_mode            (req_mode),
      .req_prefix          (req_prefix),
      .req_prefix_len      (req_prefix_len),
      .req_has_next_hop    (req_has_next_hop),
      .req_gateway_addr    (req_gateway_addr),
      .req_route_interface (req_route_interface),
      .req_dst_addr        (req_dst_addr),
      .req_ttl_in          (req_ttl_in),
      .cmd_pop             (cmd_pop),
      .cmd_empty           (cmd_empty),
      .cmd_head            (cmd_head)
   );

   // route table and scan engine; takes a command only when a result slot is free
   lpmr_back #(
      .MAX_ROUTES (MAX_ROUTES)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .cmd_empty (cmd_empty),
      .cmd_head  (cmd_head),
      .cmd_pop   (cmd_pop),
      .rsp_full  (rsp_full),
      .rsp_push  (rsp_push),
      .rsp_data  (rsp_data)
   );

   // finished results wait here until popped
   lpmr_rsp_q u_rsp_q (
      .clock     (clock),
      .reset     (reset),
      .push      (rsp_push),
      .push_data (rsp_data),
      .full      (rsp_full),
      .pop       (pop),
      .empty     (empty),
      .head      (rsp_head)
   );

   // oldest result on the ports
   assign rsp_status        = rsp_head.status;
   assign rsp_out_interface = rsp_head.iface;
   assign rsp_hop_addr      = rsp_head.hop;
   assign rsp_ttl_out       = rsp_head.ttl;

endmodule

`default_nettype wire

[src/lpmr_front.sv]
// front end: classifies incoming items and holds them in a two-entry queue
// depends on lpmr_pkg
`default_nettype none

module lpmr_front (
   input  wire logic            clock,
   input  wire logic            reset,
   input  wire logic            push,
   output logic                 full,
   input  wire logic            req_mode,
   input  wire logic [31:0]     req_prefix,
   input  wire logic [5:0]      req_prefix_len,
   input  wire logic            req_has_next_hop,
   input  wire logic [31:0]     req_gateway_addr,
   input  wire logic [3:0]      req_route_interface,
   input  wire logic [31:0]     req_dst_addr,
   input  wire logic [7:0]      req_ttl_in,
   input  wire logic            cmd_pop,
   output logic                 cmd_empty,
   output lpmr_pkg::cmd_type    cmd_head
);
   import lpmr_pkg::*;

   cmd_type    cmd_new;
   cmd_type    q_ff [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] cnt_ff, cnt_in;
   logic       do_push, do_pop;

   // classify: add, expired datagram or table lookup
   always_comb begin
      cmd_new = '0;
      if (!req_mode) begin
         cmd_new.op = OP_ADD;
      end else if (req_ttl_in <= 8'd1) begin
         cmd_new.op = OP_EXPIRED;
      end else begin
         cmd_new.op = OP_LOOKUP;
      end
      cmd_new.prefix     = req_prefix;
      cmd_new.prefix_len = (req_prefix_len > MAX_PREFIX_LEN) ? MAX_PREFIX_LEN : req_prefix_len;
      cmd_new.has_gw     = req_has_next_hop;
      cmd_new.gw         = req_gateway_addr;
      cmd_new.iface      = req_route_interface;
      cmd_new.dst        = req_dst_addr;
      cmd_new.ttl        = req_ttl_in;
   end

   assign full      = (cnt_ff == 2'd2);
   assign cmd_empty = (cnt_ff == 2'd0);
   assign cmd_head  = q_ff[rd_ptr_ff];
   assign do_push   = push && !full;
   assign do_pop    = cmd_pop && !cmd_empty;

   always_comb begin
      wr_ptr_in = do_push ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = do_pop ? ~rd_ptr_ff : rd_ptr_ff;
      cnt_in    = cnt_ff;
      if (do_push && !do_pop) begin
         cnt_in = cnt_ff + 2'd1;
      end else if (do_pop && !do_push) begin
         cnt_in = cnt_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         cnt_ff    <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         q_ff[wr_ptr_ff] <= cmd_new;
      end
   end

endmodule

`default_nettype wire

[src/lpmr_back.sv]
// back end: route table memory, add sequencer and one-entry-per-cycle lookup scan
// depends on lpmr_pkg
`default_nettype none

module lpmr_back #(
   parameter int unsigned MAX_ROUTES = lpmr_pkg::MAX_ROUTES_DEF
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              cmd_empty,
   input  wire lpmr_pkg::cmd_type cmd_head,
   output logic                   cmd_pop,
   input  wire logic              rsp_full,
   output logic                   rsp_push,
   output lpmr_pkg::rsp_type      rsp_data
);
   import lpmr_pkg::*;

   localparam int unsigned CntW = $clog2(MAX_ROUTES + 1);
   localparam int unsigned IdxW = (MAX_ROUTES > 1) ? $clog2(MAX_ROUTES) : 1;

   bk_state_type    state_ff, state_in;
   logic [CntW-1:0] count_ff, count_in;
   logic [CntW-1:0] idx_ff, idx_in;
   logic            rd_vld_ff, rd_vld_in;
   logic            found_ff, found_in;
   logic [5:0]      best_len_ff, best_len_in;
   logic            best_has_gw_ff, best_has_gw_in;
   logic [31:0]     best_gw_ff, best_gw_in;
   logic [3:0]      best_iface_ff, best_iface_in;
   logic [31:0]     dst_ff, dst_in;
   logic [7:0]      ttl_ff, ttl_in;

   entry_type       route_mem [MAX_ROUTES];
   entry_type       rd_data_ff;
   entry_type       wr_entry;
   logic            mem_we;
   logic            rd_en;
   logic            hit;

   assign wr_entry.prefix = cmd_head.prefix;
   assign wr_entry.len    = cmd_head.prefix_len;
   assign wr_entry.has_gw = cmd_head.has_gw;
   assign wr_entry.gw     = cmd_head.gw;
   assign wr_entry.iface  = cmd_head.iface;

   // stored prefix is compared unmasked
   assign hit = ((len_mask(rd_data_ff.len) & dst_ff) == rd_data_ff.prefix)
              && (!found_ff || (rd_data_ff.len > best_len_ff));

   always_comb begin
      state_in       = state_ff;
      count_in       = count_ff;
      idx_in         = idx_ff;
      rd_vld_in      = 1'b0;
      found_in       = found_ff;
      best_len_in    = best_len_ff;
      best_has_gw_in = best_has_gw_ff;
      best_gw_in     = best_gw_ff;
      best_iface_in  = best_iface_ff;
      dst_in         = dst_ff;
      ttl_in         = ttl_ff;
      cmd_pop        = 1'b0;
      rsp_push       = 1'b0;
      rsp_data       = '0;
      mem_we         = 1'b0;
      rd_en          = 1'b0;

      case (state_ff)
         BK_IDLE: begin
            if (!cmd_empty && !rsp_full) begin
               cmd_pop = 1'b1;
               case (cmd_head.op)
                  OP_ADD: begin
                     rsp_push = 1'b1;
                     if (count_ff == CntW'(MAX_ROUTES)) begin
                        rsp_data.status = ST_FULL;
                     end else begin
                        mem_we          = 1'b1;
                        count_in        = count_ff + CntW'(1);
                        rsp_data.status = ST_ADDED;
                     end
                  end
                  OP_EXPIRED: begin
                     rsp_push        = 1'b1;
                     rsp_data.status = ST_EXPIRED;
                  end
                  OP_LOOKUP: begin
                     dst_in      = cmd_head.dst;
                     ttl_in      = cmd_head.ttl;
                     idx_in      = '0;
                     found_in    = 1'b0;
                     best_len_in = 6'd0;
                     state_in    = BK_SCAN;
                  end
                  default: begin
                     rsp_push        = 1'b1;
                     rsp_data.status = ST_NOROUTE;
                  end
               endcase
            end
         end
         BK_SCAN: begin
            if (idx_ff < count_ff) begin
               rd_en     = 1'b1;
               rd_vld_in = 1'b1;
               idx_in    = idx_ff + CntW'(1);
            end
            if (rd_vld_ff && hit) begin
               found_in       = 1'b1;
               best_len_in    = rd_data_ff.len;
               best_has_gw_in = rd_data_ff.has_gw;
               best_gw_in     = rd_data_ff.gw;
               best_iface_in  = rd_data_ff.iface;
            end
            if ((idx_ff >= count_ff) && !rd_vld_ff) begin
               rsp_push = 1'b1;
               state_in = BK_IDLE;
               if (found_ff && (32'(best_iface_ff) < 32'(NUM_INTERFACES))) begin
                  rsp_data.status = ST_FORWARD;
                  rsp_data.iface  = best_iface_ff;
                  rsp_data.hop    = best_has_gw_ff ? best_gw_ff : dst_ff;
                  rsp_data.ttl    = ttl_ff - 8'd1;
               end else begin
                  rsp_data.status = ST_NOROUTE;
               end
            end
         end
         default: begin
            state_in = BK_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= BK_IDLE;
         count_ff  <= '0;
         idx_ff    <= '0;
         rd_vld_ff <= 1'b0;
         found_ff  <= 1'b0;
      end else begin
         state_ff  <= state_in;
         count_ff  <= count_in;
         idx_ff    <= idx_in;
         rd_vld_ff <= rd_vld_in;
         found_ff  <= found_in;
      end
   end

   always_ff @(posedge clock) begin
      best_len_ff    <= best_len_in;
      best_has_gw_ff <= best_has_gw_in;
      best_gw_ff     <= best_gw_in;
      best_iface_ff  <= best_iface_in;
      dst_ff         <= dst_in;
      ttl_ff         <= ttl_in;
   end

   // route table, one write port and one registered read port
   always_ff @(posedge clock) begin
      if (mem_we) begin
         route_mem[count_ff[IdxW-1:0]] <= wr_entry;
      end
      if (rd_en) begin
         rd_data_ff <= route_mem[idx_ff[IdxW-1:0]];
      end
   end

endmodule

`default_nettype wire

[src/lpmr_rsp_q.sv]
// two-entry result queue that parts the back end from the result port
// depends on lpmr_pkg
`default_nettype none

module lpmr_rsp_q (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              push,
   input  wire lpmr_pkg::rsp_type push_data,
   output logic                   full,
   input  wire logic              pop,
   output logic                   empty,
   output lpmr_pkg::rsp_type      head
);
   import lpmr_pkg::*;

   rsp_type    q_ff [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] cnt_ff, cnt_in;
   logic       do_push, do_pop;

   assign full    = (cnt_ff == 2'd2);
   assign empty   = (cnt_ff == 2'd0);
   assign head    = q_ff[rd_ptr_ff];
   assign do_push = push && !full;
   assign do_pop  = pop && !empty;

   always_comb begin
      wr_ptr_in = do_push ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = do_pop ? ~rd_ptr_ff : rd_ptr_ff;
      cnt_in    = cnt_ff;
      if (do_push && !do_pop) begin
         cnt_in = cnt_ff + 2'd1;
      end else if (do_pop && !do_push) begin
         cnt_in = cnt_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         cnt_ff    <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         q_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

`default_nettype wire

[src/lpmr_checker.sv]
// port-level checks for the longest prefix match router, bound to the top level
// depends on lpmr_pkg and assert_macros.svh
`default_nettype none

`include "assert_macros.svh"

module lpmr_checker (
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        full,
   input wire logic        empty,
   input wire logic        pop,
   input wire logic [2:0]  rsp_status,
   input wire logic [3:0]  rsp_out_interface,
   input wire logic [31:0] rsp_hop_addr,
   input wire logic [7:0]  rsp_ttl_out
);
   import lpmr_pkg::*;

   // both queues come out of reset empty
   `ASSERT_CLK(a_reset_empty, clock, reset |=> empty && !full, "queues not empty after reset")

   // a waiting result holds until popped
   `ASSERT_RST(a_rsp_hold, clock, reset, !empty && !pop |=> !empty && $stable(rsp_status) && $stable(rsp_hop_addr), "result changed before pop")

   // a forwarded datagram always leaves with a live ttl
   `ASSERT_RST(a_fwd_ttl, clock, reset, !empty && (rsp_status == ST_FORWARD) |-> rsp_ttl_out != 8'd0, "forwarded with zero ttl")

   // anything but a forward carries zero interface, hop and ttl
   `ASSERT_RST(a_non_fwd_zero, clock, reset, !empty && (rsp_status != ST_FORWARD) |-> (rsp_out_interface == 4'd0) && (rsp_hop_addr == 32'd0) && (rsp_ttl_out == 8'd0), "stray fields on non forward result")

endmodule

bind longest_prefix_match_router lpmr_checker u_lpmr_checker (.*);

`default_nettype wire

[dv/tb_longest_prefix_match_router.sv]
// self-checking testbench for the longest prefix match router
// depends on lpmr_pkg and longest_prefix_match_router; predicts every response
// from its own copy of the route table and checks each transfer in order
`timescale 1ns / 1ps

module tb_longest_prefix_match_router;
   import lpmr_pkg::*;

   localparam int CLK_PERIOD      = 10;
   localparam int ROUTE_SLOTS     = MAX_ROUTES_DEF;
   localparam int RANDOM_ITEMS    = 525;
   // no idling on either side once this few requests are left
   localparam int CALM_ITEMS      = 60;
   // cycles with no transfer on either channel before the run is called hung
   localparam int WATCHDOG_CYCLES = 2000;
   // a full-table lookup plus both queues, with margin
   localparam int SETTLE_CYCLES   = 100;

   // request mode codes
   localparam logic MODE_ADD   = 1'b0;
   localparam logic MODE_ROUTE = 1'b1;

   // one request waiting to be driven
   typedef struct {
      logic        mode;
      logic [31:0] prefix;
      logic [5:0]  prefix_len;
      logic        has_gw;
      logic [31:0] gw;
      logic [3:0]  iface;
      logic [31:0] dst;
      logic [7:0]  ttl;
      bit          hold_for_drain;
   } route_request_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        push = 1'b0;
   logic        full;
   logic        req_mode = MODE_ADD;
   logic [31:0] req_prefix = '0;
   logic [5:0]  req_prefix_len = '0;
   logic        req_has_next_hop = 1'b0;
   logic [31:0] req_gateway_addr = '0;
   logic [3:0]  req_route_interface = '0;
   logic [31:0] req_dst_addr = '0;
   logic [7:0]  req_ttl_in = '0;
   logic        empty;
   logic        pop = 1'b0;
   logic [2:0]  rsp_status;
   logic [3:0]  rsp_out_interface;
   logic [31:0] rsp_hop_addr;
   logic [7:0]  rsp_ttl_out;

   route_request_type pending_requests[$];
   rsp_type           expected_responses[$];

   // predictor's copy of the route table
   entry_type route_table[ROUTE_SLOTS];
   int        route_total = 0;

   int error_count  = 0;
   int quiet_cycles = 0;
   int req_gap_left = 0;
   int rsp_gap_left = 0;

   // stimulus side bookkeeping: routes the generator knows were stored
   logic [31:0] known_base[$];
   logic [5:0]  known_len[$];
   int          planned_routes = 0;
   bit          drain_next = 0;

   rsp_type want;

   longest_prefix_match_router uut (
      .clock               (clock),
      .reset               (reset),
      .push                (push),
      .full                (full),
      .req_mode            (req_mode),
      .req_prefix          (req_prefix),
      .req_prefix_len      (req_prefix_len),
      .req_has_next_hop    (req_has_next_hop),
      .req_gateway_addr    (req_gateway_addr),
      .req_route_interface (req_route_interface),
      .req_dst_addr        (req_dst_addr),
      .req_ttl_in          (req_ttl_in),
      .empty               (empty),
      .pop                 (pop),
      .rsp_status          (rsp_status),
      .rsp_out_interface   (rsp_out_interface),
      .rsp_hop_addr        (rsp_hop_addr),
      .rsp_ttl_out         (rsp_ttl_out)
   );

   always #(CLK_PERIOD / 2) clock = ~clock;

   // high-order len bits set; any len of 32 or more gives all ones
   function automatic logic [31:0] addr_mask(input logic [5:0] len);
      return ~(32'hFFFF_FFFF >> len);
   endfunction

   // ---------------------------------------------------------------
   // predictor: applies one request to the table copy and queues the
   // response the router must give for it
   // ---------------------------------------------------------------
   task automatic decide_route(input logic mode, input logic [31:0] prefix,
                               input logic [5:0] plen, input logic has_gw,
                               input logic [31:0] gw, input logic [3:0] iface,
                               input logic [31:0] dst, input logic [7:0] ttl);
      rsp_type r;
      bit      hit;
      int      best;
      int      k;
      r = '0;
      hit = 0;
      best = 0;
      if (mode == MODE_ADD) begin
         if (route_total >= ROUTE_SLOTS) begin
            r.status = ST_FULL;
         end else begin
            // over-long lengths are stored as a full host route
            route_table[route_total].prefix = prefix;
            route_table[route_total].len    = (plen > MAX_PREFIX_LEN) ? MAX_PREFIX_LEN : plen;
            route_table[route_total].has_gw = has_gw;
            route_table[route_total].gw     = gw;
            route_table[route_total].iface  = iface;
            route_total++;
            r.status = ST_ADDED;
         end
      end else if (ttl <= 8'd1) begin
         r.status = ST_EXPIRED;
      end else begin
         // stored prefix is compared unmasked, so stray host bits never match;
         // strict greater-than keeps the oldest route on a length tie
         for (k = 0; k < route_total; k++) begin
            if ((addr_mask(route_table[k].len) & dst) == route_table[k].prefix &&
                (!hit || route_table[k].len > route_table[best].len)) begin
               hit = 1;
               best = k;
            end
         end
         if (!hit || int'(route_table[best].iface) >= NUM_INTERFACES) begin
            r.status = ST_NOROUTE;
         end else begin
            r.status = ST_FORWARD;
            r.iface  = route_table[best].iface;
            r.hop    = route_table[best].has_gw ? route_table[best].gw : dst;
            r.ttl    = ttl - 8'd1;
         end
      end
      expected_responses = {expected_responses, r};
   endtask

   // ---------------------------------------------------------------
   // stimulus builders: unused fields carry random noise
   // ---------------------------------------------------------------
   task automatic queue_add(input logic [31:0] prefix, input logic [5:0] plen,
                            input logic has_gw, input logic [31:0] gw,
                            input logic [3:0] iface);
      route_request_type item;
      item.mode = MODE_ADD;
      item.prefix = prefix;
      item.prefix_len = plen;
      item.has_gw = has_gw;
      item.gw = gw;
      item.iface = iface;
      item.dst = $urandom();
      item.ttl = 8'($urandom_range(255, 0));
      item.hold_for_drain = drain_next;
      drain_next = 0;
      pending_requests = {pending_requests, item};
      // remember stored routes so lookups can be aimed at them
      if (planned_routes < ROUTE_SLOTS) begin
         planned_routes++;
         known_base = {known_base, prefix};
         known_len = {known_len, plen};
      end
   endtask

   task automatic queue_lookup(input logic [31:0] dst, input logic [7:0] ttl);
      route_request_type item;
      item.mode = MODE_ROUTE;
      item.prefix = $urandom();
      item.prefix_len = 6'($urandom_range(63, 0));
      item.has_gw = 1'($urandom_range(1, 0));
      item.gw = $urandom();
      item.iface = 4'($urandom_range(15, 0));
      item.dst = dst;
      item.ttl = ttl;
      item.hold_for_drain = drain_next;
      drain_next = 0;
      pending_requests = {pending_requests, item};
   endtask

   // address inside one of the known routes, host bits random
   function automatic logic [31:0] addr_near_known();
      int k;
      k = $urandom_range(known_base.size() - 1, 0);
      return known_base[k] | ($urandom() & ~addr_mask(known_len[k]));
   endfunction

   // ---------------------------------------------------------------
   // request driver: changes inputs on the falling edge, idles in bursts
   // ---------------------------------------------------------------
   always @(negedge clock) begin
      if (reset || pending_requests.size() == 0) begin
         push <= 1'b0;
      end else if (pending_requests[0].hold_for_drain && expected_responses.size() != 0) begin
         // hold off until the router has answered everything in flight
         push <= 1'b0;
      end else begin
         if (req_gap_left == 0 && pending_requests.size() > CALM_ITEMS &&
             $urandom_range(11, 0) == 0) begin
            req_gap_left = $urandom_range(17, 1);
         end
         if (req_gap_left > 0) begin
            req_gap_left--;
            push <= 1'b0;
         end else begin
            push                <= 1'b1;
            req_mode            <= pending_requests[0].mode;
            req_prefix          <= pending_requests[0].prefix;
            req_prefix_len      <= pending_requests[0].prefix_len;
            req_has_next_hop    <= pending_requests[0].has_gw;
            req_gateway_addr    <= pending_requests[0].gw;
            req_route_interface <= pending_requests[0].iface;
            req_dst_addr        <= pending_requests[0].dst;
            req_ttl_in          <= pending_requests[0].ttl;
         end
      end
   end

   // response side stall bursts, none near the end of the run
   always @(negedge clock) begin
      if (reset) begin
         pop <= 1'b0;
      end else begin
         if (rsp_gap_left == 0 && pending_requests.size() > CALM_ITEMS &&
             $urandom_range(9, 0) == 0) begin
            rsp_gap_left = $urandom_range(17, 1);
         end
         if (rsp_gap_left > 0) begin
            rsp_gap_left--;
            pop <= 1'b0;
         end else begin
            pop <= 1'b1;
         end
      end
   end

   // ---------------------------------------------------------------
   // monitor: samples both channels on the rising edge
   // responses are checked before the request of the same edge is predicted,
   // since a request can never be answered in the cycle it is accepted
   // ---------------------------------------------------------------
   always @(posedge clock) begin
      if (!reset) begin
         if (pop && !empty) begin
            if (expected_responses.size() == 0) begin
               $display("%0t: unexpected response status %0d iface %0d hop %h ttl %0d",
                        $time, rsp_status, rsp_out_interface, rsp_hop_addr, rsp_ttl_out);
               error_count++;
            end else begin
               want = expected_responses.pop_front();
               if (rsp_status !== want.status || rsp_out_interface !== want.iface ||
                   rsp_hop_addr !== want.hop || rsp_ttl_out !== want.ttl) begin
                  $display("%0t: response mismatch expected status %0d iface %0d hop %h ttl %0d",
                           $time, want.status, want.iface, want.hop, want.ttl);
                  $display("%0t:                   actual status %0d iface %0d hop %h ttl %0d",
                           $time, rsp_status, rsp_out_interface, rsp_hop_addr, rsp_ttl_out);
                  error_count++;
               end
            end
         end
         if (push && !full) begin
            decide_route(req_mode, req_prefix, req_prefix_len, req_has_next_hop,
                         req_gateway_addr, req_route_interface, req_dst_addr, req_ttl_in);
            pending_requests.delete(0);
         end
         // watchdog: any transfer on either side counts as progress
         if ((pop && !empty) || (push && !full)) begin
            quiet_cycles = 0;
         end else begin
            quiet_cycles++;
         end
      end
   end

   // ---------------------------------------------------------------
   // stimulus, reset and end of run
   // ---------------------------------------------------------------
   initial begin : stimulus
      int          i;
      logic [5:0]  plen;
      logic [31:0] base;
      logic [7:0]  ttl;
      int          pick;

      // lookups on an empty table: no route, and both expired ttl values
      queue_lookup(32'h0A01_0203, 8'd64);
      queue_lookup(32'h0A01_0203, 8'd0);
      queue_lookup(32'h0A01_0203, 8'd1);
      queue_lookup(32'hFFFF_FFFF, 8'd2);

      // default route first, then nested prefixes under 10/8 and a host route
      queue_add(32'h0000_0000, 6'd0, 1'b1, 32'hFFFF_FFFF, 4'd15);
      queue_add(32'h0A00_0000, 6'd8, 1'b0, 32'h0000_0000, 4'd1);
      queue_add(32'h0A01_0000, 6'd16, 1'b1, 32'h0A00_0001, 4'd2);
      queue_add(32'h0A01_0200, 6'd24, 1'b0, 32'hDEAD_BEEF, 4'd3);
      queue_add(32'hC0A8_0107, 6'd32, 1'b1, 32'hC0A8_0101, 4'd4);
      // same prefix and length again: the older route must keep winning
      queue_add(32'h0A00_0000, 6'd8, 1'b1, 32'h0B0B_0B0B, 4'd5);
      // host bits left set in the prefix: this route can never match
      queue_add(32'hAC10_0001, 6'd16, 1'b1, 32'hAC10_00FE, 4'd6);
      // lengths past 32 are stored as host routes
      queue_add(32'hFFFF_FFFF, 6'd63, 1'b1, 32'h1234_5678, 4'd7);
      queue_add(32'h0000_0000, 6'd40, 1'b0, 32'hFFFF_FFFF, 4'd0);

      queue_lookup(32'h0A01_0203, 8'd255);  // /24, direct
      queue_lookup(32'h0A01_0909, 8'd2);    // /16, gateway, ttl drops to one
      queue_lookup(32'h0A09_0909, 8'd100);  // /8 tie, oldest wins
      queue_lookup(32'h0B00_0000, 8'd30);   // default route
      queue_lookup(32'hC0A8_0107, 8'd17);   // exact host route
      queue_lookup(32'hFFFF_FFFF, 8'd128);  // saturated length, all ones
      queue_lookup(32'h0000_0000, 8'd9);    // saturated length, all zeros
      queue_lookup(32'hAC10_0001, 8'd40);   // falls through to default
      queue_lookup(32'h0A01_0203, 8'd1);    // matching route but expired

      // random part: mostly lookups aimed at stored routes, adds spread
      // through the run so the table fills and then overflows
      for (i = 0; i < RANDOM_ITEMS; i++) begin
         if (i % 200 == 0) begin
            drain_next = 1;
         end
         if (i % 5 == 0 || $urandom_range(19, 0) == 0) begin
            plen = ($urandom_range(4, 0) == 0) ? 6'($urandom_range(63, 33))
                                               : 6'($urandom_range(32, 0));
            // often extend or overlap a known route to make nested prefixes
            base = (known_base.size() != 0 && $urandom_range(1, 0) == 1) ?
                   addr_near_known() : $urandom();
            // mostly well formed, some with stray host bits
            if ($urandom_range(6, 0) != 0) begin
               base = base & addr_mask(plen);
            end
            queue_add(base, plen, 1'($urandom_range(1, 0)), $urandom(),
                      4'($urandom_range(15, 0)));
         end else begin
            pick = $urandom_range(9, 0);
            if (pick == 0) begin
               ttl = 8'($urandom_range(1, 0));
            end else if (pick == 1) begin
               ttl = 8'd255;
            end else begin
               ttl = 8'($urandom_range(254, 2));
            end
            base = (known_base.size() != 0 && $urandom_range(9, 0) < 7) ?
                   addr_near_known() : $urandom();
            queue_lookup(base, ttl);
         end
      end

      repeat (10) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // sampled on the falling edge so the monitor's updates have settled
      while ((pending_requests.size() != 0 || expected_responses.size() != 0) &&
             quiet_cycles < WATCHDOG_CYCLES) begin
         @(negedge clock);
      end

      if (quiet_cycles >= WATCHDOG_CYCLES) begin
         $display("%0t: no transfer for %0d cycles", $time, WATCHDOG_CYCLES);
         $display("longest_prefix_match_router verification failed");
      end else begin
         // let any stray response show up before the verdict
         repeat (SETTLE_CYCLES) @(negedge clock);
         if (error_count == 0) begin
            $display("longest_prefix_match_router verification clean");
         end else begin
            $display("longest_prefix_match_router verification failed");
         end
      end
      $finish;
   end

endmodule
